// ===== rtl/esd_pkg.sv =====
// Shared types and constants of the escape sequence decoder.
`default_nettype none

package esd_pkg;

    // Field widths.
    localparam int ESD_BYTE_W   = 8;
    localparam int ESD_STATUS_W = 2;
    localparam int ESD_LEN_W    = 10;
    localparam int ESD_NUM_W    = 10;
    localparam int ESD_DIGIT_W  = 2;

    // Most result beats that one input character can cause.
    localparam int ESD_MAX_RESULTS = 3;
    localparam int ESD_CNT_W       = $clog2(ESD_MAX_RESULTS + 1);
    localparam int ESD_IDX_W       = $clog2(ESD_MAX_RESULTS);

    // Default depth of the command queue between parser and emitter.
    localparam int ESD_QUEUE_DEPTH = 4;

    localparam logic [ESD_LEN_W-1:0] ESD_MAX_LENGTH_RESET = 10'd255;

    // Result status codes.
    localparam logic [ESD_STATUS_W-1:0] ST_BYTE = 2'd0;
    localparam logic [ESD_STATUS_W-1:0] ST_END  = 2'd1;
    localparam logic [ESD_STATUS_W-1:0] ST_OVER = 2'd2;

    // One result beat.
    typedef struct packed {
        logic [ESD_BYTE_W-1:0]   data;
        logic [ESD_STATUS_W-1:0] status;
    } result_t;

    // All the beats caused by one input character, in order.
    typedef struct packed {
        logic [ESD_CNT_W-1:0]               count;
        result_t [ESD_MAX_RESULTS-1:0]      res;
    } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/esd_if.sv =====
// Channel interfaces of the escape sequence decoder: input, result and configuration.
`default_nettype none

interface esd_in_if;
    import esd_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [ESD_BYTE_W-1:0] in_byte;
    logic                  first;

    modport source (output valid, output in_byte, output first, input ready);
    modport sink   (input valid, input in_byte, input first, output ready);
endinterface

interface esd_out_if;
    import esd_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [ESD_BYTE_W-1:0]   out_byte;
    logic [ESD_STATUS_W-1:0] status;
    logic                    last;

    modport source (output valid, output out_byte, output status, output last, input ready);
    modport sink   (input valid, input out_byte, input status, input last, output ready);
endinterface

interface esd_cfg_if;
    import esd_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [ESD_LEN_W-1:0] max_length;

    modport source (output valid, output max_length, input ready);
    modport sink   (input valid, input max_length, output ready);
endinterface

`default_nettype wire

// ===== rtl/esd_parser.sv =====
// Front end: takes input characters, runs the escape parser and builds result commands.
`default_nettype none

module esd_parser (
    input  wire logic          clk,
    input  wire logic          rst_n,
    esd_in_if.sink             in_ch,
    esd_cfg_if.sink            cfg,
    input  wire logic          q_full,
    output logic               q_push,
    output esd_pkg::cmd_t      q_cmd
);
    import esd_pkg::*;

    localparam logic [2:0] MODE_NORMAL = 3'd0;
    localparam logic [2:0] MODE_ESC    = 3'd1;
    localparam logic [2:0] MODE_DEC    = 3'd2;
    localparam logic [2:0] MODE_SIGN   = 3'd3;
    localparam logic [2:0] MODE_HEX    = 3'd4;
    localparam logic [2:0] MODE_START  = 3'd5;

    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_PLUS      = 8'h2B;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_LOW_A     = 8'h61;
    localparam logic [7:0] CH_LOW_B     = 8'h62;
    localparam logic [7:0] CH_LOW_F     = 8'h66;
    localparam logic [7:0] CH_LOW_N     = 8'h6E;
    localparam logic [7:0] CH_LOW_R     = 8'h72;
    localparam logic [7:0] CH_LOW_T     = 8'h74;
    localparam logic [7:0] CH_LOW_V     = 8'h76;
    localparam logic [7:0] CH_LOW_X     = 8'h78;
    localparam logic [7:0] CASE_BIT     = 8'h20;

    localparam logic [7:0] CODE_BEL = 8'd7;
    localparam logic [7:0] CODE_BS  = 8'd8;
    localparam logic [7:0] CODE_FF  = 8'd12;
    localparam logic [7:0] CODE_LF  = 8'd10;
    localparam logic [7:0] CODE_CR  = 8'd13;
    localparam logic [7:0] CODE_HT  = 8'd9;
    localparam logic [7:0] CODE_VT  = 8'd11;

    // Outcome of handling one character as ordinary text.
    typedef struct packed {
        logic                 hit;
        result_t              res;
        logic                 esc;
        logic                 fin;
        logic [ESD_LEN_W-1:0] pos;
    } plain_t;

    function automatic plain_t do_plain(input logic [7:0] c, input logic [ESD_LEN_W-1:0] pos,
                                        input logic [ESD_LEN_W-1:0] maxl, input logic fin);
        plain_t p;
        p.hit        = 1'b0;
        p.res.data   = '0;
        p.res.status = ST_BYTE;
        p.esc        = 1'b0;
        p.fin        = fin;
        p.pos        = pos;
        if (!fin) begin
            if (pos >= maxl) begin
                p.hit        = 1'b1;
                p.res.status = ST_OVER;
                p.fin        = 1'b1;
            end else if (c == CH_BACKSLASH) begin
                p.esc = 1'b1;
            end else if (c == CH_CR || c == CH_LF || c == CH_QUOTE || c == CH_NUL) begin
                p.hit        = 1'b1;
                p.res.status = ST_END;
                p.fin        = 1'b1;
            end else begin
                p.hit      = 1'b1;
                p.res.data = c;
                p.pos      = pos + 1'b1;
            end
        end
        return p;
    endfunction

    function automatic cmd_t push_res(input cmd_t cmd, input result_t r);
        cmd_t o;
        o = cmd;
        if (cmd.count < ESD_CNT_W'(ESD_MAX_RESULTS)) begin
            o.res[cmd.count[ESD_IDX_W-1:0]] = r;
            o.count = cmd.count + 1'b1;
        end
        return o;
    endfunction

    function automatic result_t byte_res(input logic [7:0] b);
        result_t r;
        r.data   = b;
        r.status = ST_BYTE;
        return r;
    endfunction

    // Control code for an escaped letter, or the character itself.
    function automatic logic [7:0] esc_code(input logic [7:0] c);
        logic [7:0] code;
        unique case (c | CASE_BIT)
            CH_LOW_A: code = CODE_BEL;
            CH_LOW_B: code = CODE_BS;
            CH_LOW_F: code = CODE_FF;
            CH_LOW_N: code = CODE_LF;
            CH_LOW_R: code = CODE_CR;
            CH_LOW_T: code = CODE_HT;
            CH_LOW_V: code = CODE_VT;
            default:  code = c;
        endcase
        return code;
    endfunction

    // Hex digit value with a valid flag in the top bit.
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] h;
        h = '0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            h = {1'b1, 4'(c - CH_ZERO)};
        end else if ((c | CASE_BIT) >= CH_LOW_A && (c | CASE_BIT) <= CH_LOW_F) begin
            h = {1'b1, 4'((c | CASE_BIT) - CH_LOW_A + 8'd10)};
        end
        return h;
    endfunction

    function automatic logic [7:0] num_byte(input logic [ESD_NUM_W-1:0] v, input logic neg);
        logic [ESD_NUM_W-1:0] t;
        t = neg ? (ESD_NUM_W'(0) - v) : v;
        return t[7:0];
    endfunction

    logic [2:0]             mode_reg, mode_next;
    logic [ESD_NUM_W-1:0]   nv_reg, nv_next;
    logic [ESD_DIGIT_W-1:0] dc_reg, dc_next;
    logic                   neg_reg, neg_next;
    logic [ESD_LEN_W-1:0]   pos_reg, pos_next;
    logic                   fin_reg, fin_next;
    logic [ESD_LEN_W-1:0]   max_len_reg;

    logic [2:0]             e_mode;
    logic [ESD_NUM_W-1:0]   e_nv;
    logic [ESD_DIGIT_W-1:0] e_dc;
    logic                   e_neg;
    logic [ESD_LEN_W-1:0]   e_pos;
    logic                   e_fin;

    logic [7:0]             c;
    logic                   is_digit;
    logic [3:0]             digit;
    logic [4:0]             hex;
    logic [ESD_NUM_W-1:0]   dec_acc;
    logic [ESD_DIGIT_W-1:0] dc_inc;
    logic [ESD_NUM_W-1:0]   hex_acc;
    logic [7:0]             sign_char;
    plain_t                 pa;
    plain_t                 pb;
    cmd_t                   cmd;
    logic                   accept;

    assign c        = in_ch.in_byte;
    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign digit    = 4'(c - CH_ZERO);
    assign hex      = hex_val(c);
    assign dc_inc   = e_dc + 1'b1;
    assign dec_acc  = (e_nv << 3) + (e_nv << 1) + ESD_NUM_W'(digit);
    assign hex_acc  = ESD_NUM_W'({e_nv[3:0], hex[3:0]});
    assign sign_char = e_neg ? CH_MINUS : CH_PLUS;

    assign accept      = in_ch.valid && in_ch.ready;
    assign in_ch.ready = !q_full;
    assign cfg.ready   = 1'b1;

    always_comb
    begin
        e_mode = in_ch.first ? MODE_START : mode_reg;
        e_nv   = in_ch.first ? '0 : nv_reg;
        e_dc   = in_ch.first ? '0 : dc_reg;
        e_neg  = in_ch.first ? 1'b0 : neg_reg;
        e_pos  = in_ch.first ? '0 : pos_reg;
        e_fin  = in_ch.first ? 1'b0 : fin_reg;

        mode_next = e_mode;
        nv_next   = e_nv;
        dc_next   = e_dc;
        neg_next  = e_neg;
        pos_next  = e_pos;
        fin_next  = e_fin;
        cmd       = '0;
        pa        = '0;
        pb        = '0;

        if (!e_fin) begin
            unique case (e_mode)
                MODE_START:
                begin
                    mode_next = MODE_NORMAL;
                    if (c != CH_QUOTE) begin
                        pa = do_plain(c, e_pos, max_len_reg, 1'b0);
                        if (pa.hit) cmd = push_res(cmd, pa.res);
                        mode_next = pa.esc ? MODE_ESC : MODE_NORMAL;
                        fin_next  = pa.fin;
                        pos_next  = pa.pos;
                    end
                end
                MODE_ESC:
                begin
                    nv_next  = '0;
                    dc_next  = '0;
                    neg_next = 1'b0;
                    if (is_digit) begin
                        nv_next   = ESD_NUM_W'(digit);
                        dc_next   = ESD_DIGIT_W'(1);
                        mode_next = MODE_DEC;
                    end else if (c == CH_PLUS) begin
                        mode_next = MODE_SIGN;
                    end else if (c == CH_MINUS) begin
                        neg_next  = 1'b1;
                        mode_next = MODE_SIGN;
                    end else if ((c | CASE_BIT) == CH_LOW_X) begin
                        mode_next = MODE_HEX;
                    end else begin
                        cmd       = push_res(cmd, byte_res(esc_code(c)));
                        pos_next  = e_pos + 1'b1;
                        mode_next = MODE_NORMAL;
                    end
                end
                MODE_DEC:
                begin
                    if (is_digit) begin
                        nv_next = dec_acc;
                        dc_next = dc_inc;
                        if (dc_inc >= ESD_DIGIT_W'(3)) begin
                            cmd       = push_res(cmd, byte_res(num_byte(dec_acc, e_neg)));
                            pos_next  = e_pos + 1'b1;
                            mode_next = MODE_NORMAL;
                        end
                    end else begin
                        cmd = push_res(cmd, byte_res(num_byte(e_nv, e_neg)));
                        pa  = do_plain(c, e_pos + 1'b1, max_len_reg, 1'b0);
                        if (pa.hit) cmd = push_res(cmd, pa.res);
                        mode_next = pa.esc ? MODE_ESC : MODE_NORMAL;
                        fin_next  = pa.fin;
                        pos_next  = pa.pos;
                    end
                end
                MODE_SIGN:
                begin
                    if (is_digit) begin
                        nv_next   = ESD_NUM_W'(digit);
                        dc_next   = ESD_DIGIT_W'(1);
                        mode_next = MODE_DEC;
                    end else begin
                        // A lone sign yields a zero byte, then the sign, then c.
                        neg_next = 1'b0;
                        cmd = push_res(cmd, byte_res(8'd0));
                        pa  = do_plain(sign_char, e_pos + 1'b1, max_len_reg, 1'b0);
                        if (pa.hit) cmd = push_res(cmd, pa.res);
                        pb  = do_plain(c, pa.pos, max_len_reg, pa.fin);
                        if (pb.hit) cmd = push_res(cmd, pb.res);
                        mode_next = pb.esc ? MODE_ESC : MODE_NORMAL;
                        fin_next  = pb.fin;
                        pos_next  = pb.pos;
                    end
                end
                MODE_HEX:
                begin
                    if (hex[4]) begin
                        nv_next = hex_acc;
                        dc_next = dc_inc;
                        if (dc_inc >= ESD_DIGIT_W'(2)) begin
                            cmd       = push_res(cmd, byte_res(hex_acc[7:0]));
                            pos_next  = e_pos + 1'b1;
                            mode_next = MODE_NORMAL;
                        end
                    end else begin
                        cmd = push_res(cmd, byte_res(e_nv[7:0]));
                        pa  = do_plain(c, e_pos + 1'b1, max_len_reg, 1'b0);
                        if (pa.hit) cmd = push_res(cmd, pa.res);
                        mode_next = pa.esc ? MODE_ESC : MODE_NORMAL;
                        fin_next  = pa.fin;
                        pos_next  = pa.pos;
                    end
                end
                default:
                begin
                    pa = do_plain(c, e_pos, max_len_reg, 1'b0);
                    if (pa.hit) cmd = push_res(cmd, pa.res);
                    mode_next = pa.esc ? MODE_ESC : MODE_NORMAL;
                    fin_next  = pa.fin;
                    pos_next  = pa.pos;
                end
            endcase
        end
    end

    assign q_push = accept && (cmd.count != '0);
    assign q_cmd  = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg    <= MODE_START;
            nv_reg      <= '0;
            dc_reg      <= '0;
            neg_reg     <= 1'b0;
            pos_reg     <= '0;
            fin_reg     <= 1'b0;
            max_len_reg <= ESD_MAX_LENGTH_RESET;
        end else begin
            if (accept) begin
                mode_reg <= mode_next;
                nv_reg   <= nv_next;
                dc_reg   <= dc_next;
                neg_reg  <= neg_next;
                pos_reg  <= pos_next;
                fin_reg  <= fin_next;
            end
            if (cfg.valid && cfg.ready) begin
                max_len_reg <= cfg.max_length;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/esd_cmd_queue.sv =====
// Short command queue between the parser and the result emitter.
`default_nettype none

module esd_cmd_queue #(
    parameter int DEPTH = esd_pkg::ESD_QUEUE_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire esd_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire logic          pop,
    output esd_pkg::cmd_t      head_cmd,
    output logic               empty
);
    import esd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/esd_emitter.sv =====
// Back end: plays each queued command out as one to three result beats.
`default_nettype none

module esd_emitter (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire esd_pkg::cmd_t head_cmd,
    input  wire logic          empty,
    output logic               pop,
    esd_out_if.source          out_ch
);
    import esd_pkg::*;

    logic [ESD_IDX_W-1:0] idx_reg, idx_next;
    logic                 is_last;
    logic                 beat;
    result_t              cur;

    assign cur     = head_cmd.res[idx_reg];
    assign is_last = (ESD_CNT_W'(idx_reg) == head_cmd.count - 1'b1);
    assign beat    = out_ch.valid && out_ch.ready;
    assign pop     = beat && is_last;

    assign out_ch.valid    = !empty;
    assign out_ch.out_byte = cur.data;
    assign out_ch.status   = cur.status;
    assign out_ch.last     = is_last;

    always_comb
    begin
        idx_next = idx_reg;
        if (beat) begin
            idx_next = is_last ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg <= '0;
        end else begin
            idx_reg <= idx_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/escape_sequence_decoder.sv =====
// Top level of the escape sequence decoder: parser, command queue and result emitter.
`default_nettype none

// The decoder takes a quoted C-style string one raw character per input beat, with
// first set on the opening character, and returns the decoded bytes as result beats.
// The parser takes a character in every cycle in which the command queue has room:
// its whole escape state (mode, running number, digit count, sign, output position)
// updates in that cycle, and it turns the character into a command holding the
// zero to three results that the character causes. The emitter plays each command out
// at one result beat per cycle while the result side is ready, with last set on the
// final beat of that character. A character that ends a lone sign escape (zero byte,
// the sign, then itself) gives up to three result beats; the queue of QUEUE_DEPTH
// commands absorbs such bursts and lets either side stall without stopping the other.
// Characters that cause no result (a backslash, escape digits, anything after the
// string ended) never enter the queue. Status 0 carries a decoded byte, status 1 marks
// the terminator (an unescaped CR, LF, quote or NUL) and status 2 marks overflow,
// raised by the first character that arrives once max_length bytes were produced;
// after either, characters give nothing until the next first. max_length is written
// through the configuration channel, which is always ready, and resets to 255.
module escape_sequence_decoder #(
    parameter int QUEUE_DEPTH = esd_pkg::ESD_QUEUE_DEPTH
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    esd_in_if.sink      in_ch,
    esd_out_if.source   out_ch,
    esd_cfg_if.sink     cfg
);
    import esd_pkg::*;

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    cmd_t q_in_cmd;
    cmd_t q_head_cmd;

    // The parser decides every result of a character at the moment it is accepted.
    esd_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .cfg    (cfg),
        .q_full (q_full),
        .q_push (q_push),
        .q_cmd  (q_in_cmd)
    );

    // The queue decouples the input side from the result side.
    esd_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_in_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head_cmd (q_head_cmd),
        .empty    (q_empty)
    );

    // The emitter pops a command once its last beat has been taken.
    esd_emitter u_emitter (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_cmd (q_head_cmd),
        .empty    (q_empty),
        .pop      (q_pop),
        .out_ch   (out_ch)
    );

endmodule

`default_nettype wire
